// ===== rtl/core/sps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the sparse polynomial subtract block.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int DEFAULT_MAX_TERMS = 16;
    localparam int COEF_W            = 16;
    localparam int EXP_W             = 8;
    localparam int RES_W             = COEF_W + 1;
    localparam int OP_W              = 2;

    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

    typedef struct packed {
        logic [EXP_W-1:0]         exp;
        logic signed [COEF_W-1:0] coef;
    } sps_term_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic sel_b;
        logic rd_j;
        logic merge_rd;
        logic cur_load;
        logic cmp_step;
        logic wr_cur_i;
        logic ij_clr;
        logic i_inc;
        logic j_from_i;
        logic j_inc;
        logic merge_step;
        logic emit_empty;
        logic clear_all;
    } sps_cmd_t;

    typedef struct packed {
        logic i_lt_n;
        logic j_lt_n;
        logic merge_done;
        logic both_empty;
    } sps_status_t;

endpackage

// ===== rtl/core/sps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_ctrl
// Sequencer: accepts items, walks the exchange sort of each polynomial and
// the merge, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module sps_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sps_pkg::OP_W-1:0]    opcode,
    output logic                        busy,
    output sps_pkg::sps_cmd_t           cmd,
    input  sps_pkg::sps_status_t        status
);
    import sps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_I,
        ST_LOAD_I,
        ST_READ_J,
        ST_COMPARE,
        ST_WRITE_I,
        ST_MERGE_RD,
        ST_MERGE_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   sel_b_reg, sel_b_next;
    logic   busy_reg;

    assign busy = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        cmd        = '0;
        cmd.sel_b  = sel_b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_a = (opcode == OP_LOAD_FIRST);
                    cmd.load_b = (opcode == OP_LOAD_SECOND);
                    if (opcode == OP_COMPUTE)
                    begin
                        cmd.ij_clr = 1'b1;
                        sel_b_next = 1'b0;
                        state_next = ST_READ_I;
                    end
                end
            end
            ST_READ_I:
            begin
                if (status.i_lt_n)
                begin
                    state_next = ST_LOAD_I;
                end
                else
                begin
                    cmd.ij_clr = 1'b1;
                    if (sel_b_reg)
                    begin
                        state_next = ST_MERGE_RD;
                    end
                    else
                    begin
                        sel_b_next = 1'b1;
                    end
                end
            end
            ST_LOAD_I:
            begin
                cmd.cur_load = 1'b1;
                cmd.j_from_i = 1'b1;
                state_next   = ST_READ_J;
            end
            ST_READ_J:
            begin
                cmd.rd_j = 1'b1;
                if (status.j_lt_n)
                begin
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_WRITE_I;
                end
            end
            ST_COMPARE:
            begin
                cmd.rd_j     = 1'b1;
                cmd.cmp_step = 1'b1;
                cmd.j_inc    = 1'b1;
                state_next   = ST_READ_J;
            end
            ST_WRITE_I:
            begin
                cmd.wr_cur_i = 1'b1;
                cmd.i_inc    = 1'b1;
                state_next   = ST_READ_I;
            end
            ST_MERGE_RD:
            begin
                cmd.merge_rd = 1'b1;
                if (status.both_empty)
                begin
                    cmd.emit_empty = 1'b1;
                    cmd.clear_all  = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.merge_done)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MERGE_EMIT;
                end
            end
            ST_MERGE_EMIT:
            begin
                cmd.merge_rd   = 1'b1;
                cmd.merge_step = 1'b1;
                state_next     = ST_MERGE_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_b_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_b_reg <= sel_b_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

endmodule

// ===== rtl/core/sps_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_dpath
// Term memories, counts, sort/merge indexes, compare and subtract logic and
// the result register.
// ----------------------------------------------------------------------------
module sps_dpath #(
    parameter int MAX_TERMS = sps_pkg::DEFAULT_MAX_TERMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [sps_pkg::COEF_W-1:0]   coefficient,
    input  logic [sps_pkg::EXP_W-1:0]           exponent,
    input  sps_pkg::sps_cmd_t                   cmd,
    output sps_pkg::sps_status_t                status,
    output logic                                result_valid,
    output logic                                term_valid,
    output logic signed [sps_pkg::RES_W-1:0]    result_coefficient,
    output logic [sps_pkg::EXP_W-1:0]           result_exponent,
    output logic                                last,
    output logic                                overflowed
);
    import sps_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_TERMS);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    sps_term_t mem_a [MAX_TERMS];
    sps_term_t mem_b [MAX_TERMS];

    sps_term_t rd_a_reg, rd_b_reg;
    sps_term_t cur_reg, cur_next;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    logic [CNT_W-1:0] n_sel;
    sps_term_t        sort_term;
    logic             swap;
    logic [IDX_W-1:0] i_idx, j_idx, sort_addr, rd_addr_a, rd_addr_b;
    logic             sort_wr;
    logic             wr_en_a, wr_en_b;
    logic [IDX_W-1:0] wr_addr_a, wr_addr_b;
    sps_term_t        wr_data_a, wr_data_b, in_term;
    logic             room_a, room_b;

    logic             in_a, in_b, take_eq, take_b;
    logic [CNT_W-1:0] i_mrg, j_mrg;
    logic signed [RES_W-1:0] ca_ext, cb_ext, m_coef;
    logic [EXP_W-1:0] m_exp;
    logic             m_last;

    logic result_valid_reg;
    logic term_valid_reg, last_reg, ovf_out_reg;
    logic signed [RES_W-1:0] coef_out_reg;
    logic [EXP_W-1:0] exp_out_reg;

    assign i_idx     = i_reg[IDX_W-1:0];
    assign j_idx     = j_reg[IDX_W-1:0];
    assign n_sel     = cmd.sel_b ? cnt_b_reg : cnt_a_reg;
    assign sort_term = cmd.sel_b ? rd_b_reg : rd_a_reg;
    assign swap      = (cur_reg.exp < sort_term.exp);
    assign sort_addr = cmd.rd_j ? j_idx : i_idx;
    assign rd_addr_a = cmd.merge_rd ? i_idx : sort_addr;
    assign rd_addr_b = cmd.merge_rd ? j_idx : sort_addr;
    assign room_a    = (cnt_a_reg < CAP);
    assign room_b    = (cnt_b_reg < CAP);

    assign in_term.exp  = exponent;
    assign in_term.coef = coefficient;

    // sort write-back: displaced term goes to j, running max returns to i
    assign sort_wr   = (cmd.cmp_step && swap) || cmd.wr_cur_i;
    assign wr_en_a   = (cmd.load_a && room_a) || (sort_wr && !cmd.sel_b);
    assign wr_en_b   = (cmd.load_b && room_b) || (sort_wr && cmd.sel_b);
    assign wr_addr_a = cmd.load_a ? cnt_a_reg[IDX_W-1:0] : (cmd.wr_cur_i ? i_idx : j_idx);
    assign wr_addr_b = cmd.load_b ? cnt_b_reg[IDX_W-1:0] : (cmd.wr_cur_i ? i_idx : j_idx);
    assign wr_data_a = cmd.load_a ? in_term : cur_reg;
    assign wr_data_b = cmd.load_b ? in_term : cur_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en_a)
        begin
            mem_a[wr_addr_a] <= wr_data_a;
        end
        if (wr_en_b)
        begin
            mem_b[wr_addr_b] <= wr_data_b;
        end
        rd_a_reg <= mem_a[rd_addr_a];
        rd_b_reg <= mem_b[rd_addr_b];
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.cur_load || (cmd.cmp_step && swap))
        begin
            cur_next = sort_term;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // merge decision
    assign in_a   = (i_reg < cnt_a_reg);
    assign in_b   = (j_reg < cnt_b_reg);
    assign ca_ext = RES_W'(rd_a_reg.coef);
    assign cb_ext = RES_W'(rd_b_reg.coef);

    always_comb
    begin
        take_eq = in_a && in_b && (rd_a_reg.exp == rd_b_reg.exp);
        take_b  = !take_eq && in_b && (!in_a || (rd_a_reg.exp < rd_b_reg.exp));
        i_mrg   = i_reg;
        j_mrg   = j_reg;
        if (take_eq)
        begin
            m_exp  = rd_a_reg.exp;
            m_coef = ca_ext - cb_ext;
            i_mrg  = i_reg + ONE;
            j_mrg  = j_reg + ONE;
        end
        else if (take_b)
        begin
            m_exp  = rd_b_reg.exp;
            m_coef = -cb_ext;
            j_mrg  = j_reg + ONE;
        end
        else
        begin
            m_exp  = rd_a_reg.exp;
            m_coef = ca_ext;
            i_mrg  = i_reg + ONE;
        end
        m_last = (i_mrg >= cnt_a_reg) && (j_mrg >= cnt_b_reg);
    end

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.ij_clr)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cmd.merge_step)
        begin
            i_next = i_mrg;
            j_next = j_mrg;
        end
        else if (cmd.i_inc)
        begin
            i_next = i_reg + ONE;
        end
        else if (cmd.j_from_i)
        begin
            j_next = i_reg + ONE;
        end
        else if (cmd.j_inc)
        begin
            j_next = j_reg + ONE;
        end
    end

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        if (cmd.clear_all)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.load_a)
        begin
            if (room_a)
            begin
                cnt_a_next = cnt_a_reg + ONE;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else if (cmd.load_b)
        begin
            if (room_b)
            begin
                cnt_b_next = cnt_b_reg + ONE;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg        <= '0;
            cnt_b_reg        <= '0;
            ovf_reg          <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg        <= cnt_a_next;
            cnt_b_reg        <= cnt_b_next;
            ovf_reg          <= ovf_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            result_valid_reg <= cmd.merge_step || cmd.emit_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.merge_step)
        begin
            term_valid_reg <= 1'b1;
            coef_out_reg   <= m_coef;
            exp_out_reg    <= m_exp;
            last_reg       <= m_last;
            ovf_out_reg    <= ovf_reg;
        end
        else if (cmd.emit_empty)
        begin
            term_valid_reg <= 1'b0;
            coef_out_reg   <= '0;
            exp_out_reg    <= '0;
            last_reg       <= 1'b1;
            ovf_out_reg    <= ovf_reg;
        end
    end

    assign status.i_lt_n     = (i_reg < n_sel);
    assign status.j_lt_n     = (j_reg < n_sel);
    assign status.merge_done = !in_a && !in_b;
    assign status.both_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);

    assign result_valid       = result_valid_reg;
    assign term_valid         = term_valid_reg;
    assign result_coefficient = coef_out_reg;
    assign result_exponent    = exp_out_reg;
    assign last               = last_reg;
    assign overflowed         = ovf_out_reg;

endmodule

// ===== rtl/core/sparse_polynomial_subtract.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_subtract
// Difference of two sparse polynomials (first minus second) by sort and merge.
// ----------------------------------------------------------------------------
// An item transfers when start is high and busy is low. Load items and unused
// opcodes leave busy low, so they can be issued back to back. A compute item
// holds busy high while each term memory is exchange-sorted in place through
// its single read port and then merged into the results. Each result is shown
// for one cycle with result_valid and cannot be stalled; last marks the final
// result. Busy falls at the edge that ends the last result, or at the edge
// that raises the single result when both polynomials are empty.
// ----------------------------------------------------------------------------
module sparse_polynomial_subtract #(
    parameter int MAX_TERMS = sps_pkg::DEFAULT_MAX_TERMS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sps_pkg::OP_W-1:0]            opcode,
    input  logic signed [sps_pkg::COEF_W-1:0]   coefficient,
    input  logic [sps_pkg::EXP_W-1:0]           exponent,
    output logic                                result_valid,
    output logic                                term_valid,
    output logic signed [sps_pkg::RES_W-1:0]    result_coefficient,
    output logic [sps_pkg::EXP_W-1:0]           result_exponent,
    output logic                                last,
    output logic                                overflowed
);
    import sps_pkg::*;

    sps_cmd_t    cmd;
    sps_status_t status;

    sps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    sps_dpath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .coefficient        (coefficient),
        .exponent           (exponent),
        .cmd                (cmd),
        .status             (status),
        .result_valid       (result_valid),
        .term_valid         (term_valid),
        .result_coefficient (result_coefficient),
        .result_exponent    (result_exponent),
        .last               (last),
        .overflowed         (overflowed)
    );

endmodule
